@@ rtl/pfc_pkg.sv @@
// Shared constants, types and helper functions for the Playfair digraph cipher.
package pfc_pkg;

  localparam logic [4:0] LET_I = 5'd8;
  localparam logic [4:0] LET_J = 5'd9;
  localparam logic [4:0] LET_X = 5'd23;
  localparam logic [4:0] CELLS = 5'd25;
  localparam logic [4:0] ALPHA = 5'd26;
  localparam logic [4:0] LAST_LETTER = 5'd25;

  localparam logic [1:0] MODE_KEY  = 2'd0;
  localparam logic [1:0] MODE_TEXT = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_FILL = 7'b0000010,
    S_TEXT = 7'b0000100,
    S_PLB  = 7'b0001000,
    S_PLD  = 7'b0010000,
    S_SQ1  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  // Access requests from the sequencer to the square and place memories.
  typedef struct packed {
    logic       sq_we;
    logic [4:0] sq_waddr;
    logic [4:0] sq_wdata;
    logic       sq_re;
    logic [4:0] sq_raddr;
    logic       pl_we;
    logic [4:0] pl_waddr;
    logic [4:0] pl_wdata;
    logic       pl_re;
    logic [4:0] pl_raddr;
  } mem_req_t;

  // Load of one finished digraph into the output buffer.
  typedef struct packed {
    logic       ld;
    logic [4:0] first;
    logic [4:0] second;
  } ob_load_t;

  function automatic logic [2:0] cell_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] p);
    logic [4:0] rr;
    logic [4:0] d;
    rr = {2'b00, cell_row(p)};
    d  = p - ((rr << 2) + rr);
    return d[2:0];
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
    logic [4:0] rr;
    rr = {2'b00, r};
    return (rr << 2) + rr + {2'b00, c};
  endfunction

  // Step one place along a row or column, wrapping around the square.
  function automatic logic [2:0] step5(input logic [2:0] v, input logic back);
    logic [2:0] s;
    if (back) s = (v == 3'd0) ? 3'd4 : v - 3'd1;
    else      s = (v == 3'd4) ? 3'd0 : v + 3'd1;
    return s;
  endfunction

endpackage

@@ rtl/pfc_store.sv @@
// Square and letter-place memories with registered read data.
module pfc_store (
  input  logic              clk,
  input  pfc_pkg::mem_req_t req,
  output logic [4:0]        sq_rdata,
  output logic [4:0]        pl_rdata
);

  logic [4:0] sq_mem [0:24];
  logic [4:0] pl_mem [0:25];
  logic [4:0] sq_rdata_r;
  logic [4:0] pl_rdata_r;

  always_ff @(posedge clk) begin
    if (req.sq_we) begin
      sq_mem[req.sq_waddr] <= req.sq_wdata;
    end
    if (req.sq_re) begin
      sq_rdata_r <= sq_mem[req.sq_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.pl_we) begin
      pl_mem[req.pl_waddr] <= req.pl_wdata;
    end
    if (req.pl_re) begin
      pl_rdata_r <= pl_mem[req.pl_raddr];
    end
  end

  assign sq_rdata = sq_rdata_r;
  assign pl_rdata = pl_rdata_r;

endmodule

@@ rtl/pfc_outbuf.sv @@
// Two-letter output buffer that presents a digraph on the result stream.
module pfc_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  pfc_pkg::ob_load_t load,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [4:0]        out_letter,
  output logic              out_last
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [4:0] first_r, second_r;

  assign out_valid  = (cnt_r != 2'd0);
  assign out_last   = (cnt_r == 2'd1);
  assign out_letter = (cnt_r == 2'd2) ? first_r : second_r;
  assign free       = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (out_valid && out_ready) begin
      cnt_nxt = cnt_r - 2'd1;
    end
    if (load.ld) begin
      cnt_nxt = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load.ld) begin
      first_r  <= load.first;
      second_r <= load.second;
    end
  end

endmodule

@@ rtl/pfc_ctrl.sv @@
// Sequencer: key placement, square completion and digraph lookups.
module pfc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [4:0]        in_letter,
  output pfc_pkg::mem_req_t req,
  input  logic [4:0]        sq_rdata,
  input  logic [4:0]        pl_rdata,
  input  logic              ob_free,
  output pfc_pkg::ob_load_t ob_ld
);

  pfc_pkg::state_t state_r, state_nxt;
  logic        dir_r;
  logic [25:0] used_r, used_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic        done_r, done_nxt;
  logic        held_r, held_nxt;
  logic [4:0]  held_let_r, held_let_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [4:0]  cur_r, cur_nxt;
  logic        is_end_r, is_end_nxt;
  logic [4:0]  b_r, b_nxt;
  logic [4:0]  pa_r, pa_nxt;
  logic [4:0]  o1a_r, o1a_nxt;
  logic [4:0]  o0_r, o0_nxt;

  logic        acc;
  logic [4:0]  let_map;
  logic [25:0] used_base;
  logic [4:0]  fill_base;
  logic [2:0]  r0, c0, r1, c1;

  assign in_ready = (state_r == pfc_pkg::S_IDLE);
  assign acc      = in_valid && in_ready;
  assign let_map  = (in_letter == pfc_pkg::LET_J) ? pfc_pkg::LET_I : in_letter;
  // A key letter after text starts from an empty square.
  assign used_base = done_r ? 26'd0 : used_r;
  assign fill_base = done_r ? 5'd0 : fill_r;

  assign r0 = pfc_pkg::cell_row(pa_r);
  assign c0 = pfc_pkg::cell_col(pa_r);
  assign r1 = pfc_pkg::cell_row(pl_rdata);
  assign c1 = pfc_pkg::cell_col(pl_rdata);

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    fill_nxt     = fill_r;
    done_nxt     = done_r;
    held_nxt     = held_r;
    held_let_nxt = held_let_r;
    idx_nxt      = idx_r;
    cur_nxt      = cur_r;
    is_end_nxt   = is_end_r;
    b_nxt        = b_r;
    pa_nxt       = pa_r;
    o1a_nxt      = o1a_r;
    o0_nxt       = o0_r;
    req          = '0;
    ob_ld        = '0;

    unique case (state_r)
      pfc_pkg::S_IDLE: begin
        if (acc) begin
          unique case (in_mode)
            pfc_pkg::MODE_KEY: begin
              if (in_letter < pfc_pkg::ALPHA) begin
                if (done_r) begin
                  done_nxt     = 1'b0;
                  held_nxt     = 1'b0;
                  held_let_nxt = 5'd0;
                end
                used_nxt = used_base;
                fill_nxt = fill_base;
                if (!used_base[let_map] && (fill_base < pfc_pkg::CELLS)) begin
                  req.sq_we    = 1'b1;
                  req.sq_waddr = fill_base;
                  req.sq_wdata = let_map;
                  req.pl_we    = 1'b1;
                  req.pl_waddr = let_map;
                  req.pl_wdata = fill_base;
                  used_nxt     = used_base | (26'd1 << let_map);
                  fill_nxt     = fill_base + 5'd1;
                end
              end
            end
            pfc_pkg::MODE_TEXT: begin
              if (in_letter < pfc_pkg::ALPHA) begin
                cur_nxt    = let_map;
                is_end_nxt = 1'b0;
                idx_nxt    = 5'd0;
                state_nxt  = done_r ? pfc_pkg::S_TEXT : pfc_pkg::S_FILL;
              end
            end
            pfc_pkg::MODE_END: begin
              is_end_nxt = 1'b1;
              idx_nxt    = 5'd0;
              state_nxt  = done_r ? pfc_pkg::S_TEXT : pfc_pkg::S_FILL;
            end
            default: begin
            end
          endcase
        end
      end

      // Walk the alphabet once and place every letter still missing except 'j'.
      pfc_pkg::S_FILL: begin
        if ((idx_r != pfc_pkg::LET_J) && !used_r[idx_r] && (fill_r < pfc_pkg::CELLS)) begin
          req.sq_we    = 1'b1;
          req.sq_waddr = fill_r;
          req.sq_wdata = idx_r;
          req.pl_we    = 1'b1;
          req.pl_waddr = idx_r;
          req.pl_wdata = fill_r;
          used_nxt     = used_r | (26'd1 << idx_r);
          fill_nxt     = fill_r + 5'd1;
        end
        idx_nxt = idx_r + 5'd1;
        if (idx_r == pfc_pkg::LAST_LETTER) begin
          done_nxt  = 1'b1;
          state_nxt = pfc_pkg::S_TEXT;
        end
      end

      // Pairing decision; a pair always starts with the held letter.
      pfc_pkg::S_TEXT: begin
        req.pl_raddr = held_let_r;
        if (is_end_r) begin
          if (held_r) begin
            b_nxt      = pfc_pkg::LET_X;
            held_nxt   = 1'b0;
            req.pl_re  = 1'b1;
            state_nxt  = pfc_pkg::S_PLB;
          end else begin
            state_nxt = pfc_pkg::S_IDLE;
          end
        end else if (!held_r) begin
          held_nxt     = 1'b1;
          held_let_nxt = cur_r;
          state_nxt    = pfc_pkg::S_IDLE;
        end else if (held_let_r == cur_r) begin
          b_nxt     = pfc_pkg::LET_X;
          req.pl_re = 1'b1;
          state_nxt = pfc_pkg::S_PLB;
        end else begin
          b_nxt     = cur_r;
          held_nxt  = 1'b0;
          req.pl_re = 1'b1;
          state_nxt = pfc_pkg::S_PLB;
        end
      end

      pfc_pkg::S_PLB: begin
        req.pl_re    = 1'b1;
        req.pl_raddr = b_r;
        pa_nxt       = pl_rdata;
        state_nxt    = pfc_pkg::S_PLD;
      end

      pfc_pkg::S_PLD: begin
        req.sq_re = 1'b1;
        if (r0 == r1) begin
          req.sq_raddr = pfc_pkg::cell_addr(r0, pfc_pkg::step5(c0, dir_r));
          o1a_nxt      = pfc_pkg::cell_addr(r1, pfc_pkg::step5(c1, dir_r));
        end else if (c0 == c1) begin
          req.sq_raddr = pfc_pkg::cell_addr(pfc_pkg::step5(r0, dir_r), c0);
          o1a_nxt      = pfc_pkg::cell_addr(pfc_pkg::step5(r1, dir_r), c1);
        end else begin
          req.sq_raddr = pfc_pkg::cell_addr(r0, c1);
          o1a_nxt      = pfc_pkg::cell_addr(r1, c0);
        end
        state_nxt = pfc_pkg::S_SQ1;
      end

      pfc_pkg::S_SQ1: begin
        req.sq_re    = 1'b1;
        req.sq_raddr = o1a_r;
        o0_nxt       = sq_rdata;
        state_nxt    = pfc_pkg::S_OUT;
      end

      // The second letter stays in the square read register until loaded.
      pfc_pkg::S_OUT: begin
        if (ob_free) begin
          ob_ld.ld     = 1'b1;
          ob_ld.first  = o0_r;
          ob_ld.second = sq_rdata;
          state_nxt    = pfc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pfc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pfc_pkg::S_IDLE;
      dir_r      <= 1'b0;
      used_r     <= 26'd0;
      fill_r     <= 5'd0;
      done_r     <= 1'b0;
      held_r     <= 1'b0;
      held_let_r <= 5'd0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      done_r     <= done_nxt;
      held_r     <= held_nxt;
      held_let_r <= held_let_nxt;
      if (cfg_wr_en) begin
        dir_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cur_r    <= cur_nxt;
    is_end_r <= is_end_nxt;
    b_r      <= b_nxt;
    pa_r     <= pa_nxt;
    o1a_r    <= o1a_nxt;
    o0_r     <= o0_nxt;
  end

endmodule

@@ rtl/playfair_digraph_cipher.sv @@
// Top level of the Playfair digraph cipher.
// A key letter is placed in its transfer cycle; a text letter that closes a digraph goes
// through a decision, two place reads, two square reads and a load before out_tvalid rises,
// after a walk of the alphabet when it first completes the square. Key letters are taken
// every cycle; no letter is taken while a text letter is in work, and an output stall holds it.
// Reset clears the control state and the output buffer; memory contents are not cleared.
module playfair_digraph_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // direction
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [4:0] letter
  input  logic [1:0] in_tuser,      // [1:0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [4:0] out_letter
  output logic       out_tlast
);

  pfc_pkg::mem_req_t req;
  pfc_pkg::ob_load_t ob_ld;
  logic [4:0] sq_rdata;
  logic [4:0] pl_rdata;
  logic       ob_free;
  logic [4:0] out_letter;

  pfc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (in_tuser),
    .in_letter   (in_tdata[4:0]),
    .req         (req),
    .sq_rdata    (sq_rdata),
    .pl_rdata    (pl_rdata),
    .ob_free     (ob_free),
    .ob_ld       (ob_ld)
  );

  pfc_store u_store (
    .clk      (clk),
    .req      (req),
    .sq_rdata (sq_rdata),
    .pl_rdata (pl_rdata)
  );

  pfc_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ob_ld),
    .free       (ob_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_letter (out_letter),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'b000, out_letter};

endmodule

@@ rtl/pfc_checker.sv @@
// Port-level checks for the Playfair digraph cipher, bound to the top level.
module pfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // A stalled result holds its letter and position.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The square never holds 'j' and letters stay in the alphabet.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] != pfc_pkg::LET_J) && (out_tdata[4:0] < pfc_pkg::ALPHA)
                   && (out_tdata[7:5] == 3'd0))
    else $error("result letter out of range");

  // The first letter of a digraph is always followed at once by its second.
  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("second letter of digraph missing");

  // After a second letter, the next shown letter opens a new digraph.
  a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || !out_tlast)
    else $error("digraph started with a second letter");

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
